### hw/rtl/glb_json_structure_check_assert.svh
// assertion macros used by the checker file
`ifndef GLB_JSON_STRUCTURE_CHECK_ASSERT_SVH
`define GLB_JSON_STRUCTURE_CHECK_ASSERT_SVH

// same-cycle implication, sampled on i_clk, off during reset
`define GJSC_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("gjsc assertion failed");

// next-cycle implication, sampled on i_clk, off during reset
`define GJSC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("gjsc assertion failed");

`endif

### hw/rtl/gjsc_pkg.sv
// constants and status codes of the glb / json structure check
package gjsc_pkg;

    localparam int DEPTH_BITS = 16;
    localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = {DEPTH_BITS{1'b1}};

    localparam logic [31:0] GLB_MAGIC     = 32'h46546C67;
    localparam logic [31:0] GLB_JSON_TYPE = 32'h4E4F534A;
    localparam logic [31:0] GLB_VERSION   = 32'd2;
    localparam logic [31:0] GLB_MIN_BYTES = 32'd20;

    localparam logic [3:0] ST_OK           = 4'd0;
    localparam logic [3:0] ST_GLB_SHORT    = 4'd1;
    localparam logic [3:0] ST_BAD_VERSION  = 4'd2;
    localparam logic [3:0] ST_LEN_MISMATCH = 4'd3;
    localparam logic [3:0] ST_NOT_JSON_CHK = 4'd4;
    localparam logic [3:0] ST_BAD_CHUNK    = 4'd5;
    localparam logic [3:0] ST_NOT_OBJ      = 4'd6;
    localparam logic [3:0] ST_EARLY_CLOSE  = 4'd7;
    localparam logic [3:0] ST_UNTERM       = 4'd8;
    localparam logic [3:0] ST_OVERFLOW     = 4'd9;

    localparam logic [1:0] JE_NONE        = 2'd0;
    localparam logic [1:0] JE_NOT_OBJ     = 2'd1;
    localparam logic [1:0] JE_EARLY_CLOSE = 2'd2;
    localparam logic [1:0] JE_DEPTH_OVF   = 2'd3;

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

endpackage

### hw/rtl/glb_json_structure_check.sv
// glb / json payload structure check, one byte per beat
//
// Input channel: i_valid, i_data_byte, i_last_byte, with o_stall back to the
// sender. A beat is taken at a rising edge with i_valid high and o_stall low.
// Output channel: o_valid and the result fields, with i_stall from the
// receiver. One result beat follows the beat that carries i_last_byte; other
// beats give no result.
// Throughput: one byte per cycle while o_stall is low. Every byte updates the
// header words, the bracket depth and the byte counter when it is taken.
// The result is loaded into the output register at the edge that takes the
// last byte.
// While the receiver stalls, the result holds; further bytes are still taken
// until a new final byte needs the output register, then o_stall rises.
// Reset (i_rst_n low at a clock edge) clears the payload state and drops
// o_valid; the block is ready in the next cycle. After each final byte the
// state returns to its reset values for the next payload.
module glb_json_structure_check (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_payload_ok,
    output logic        o_payload_kind,
    output logic [3:0]  o_status_code,
    output logic [31:0] o_total_bytes,
    output logic [31:0] o_chunk_length
);
    import gjsc_pkg::*;

    logic [31:0]           r_count,     n_count;
    logic                  r_ovf,       n_ovf;
    logic                  r_prefix,    n_prefix;
    logic [31:0]           r_version,   n_version;
    logic [31:0]           r_decl_len,  n_decl_len;
    logic [31:0]           r_chunk_len, n_chunk_len;
    logic [31:0]           r_chunk_typ, n_chunk_typ;
    logic [DEPTH_BITS-1:0] r_depth,     n_depth;
    logic                  r_in_str,    n_in_str;
    logic                  r_escape,    n_escape;
    logic                  r_started,   n_started;
    logic [1:0]            r_jerr,      n_jerr;

    logic                  r_out_valid, n_out_valid;
    logic                  r_out_ok;
    logic                  r_out_kind;
    logic [3:0]            r_out_status;
    logic [31:0]           r_out_total;
    logic [31:0]           r_out_chunk;

    logic                  accept;
    logic                  is_ws, is_open, is_close;
    logic [1:0]            lane;
    logic                  glb;
    logic [3:0]            status;
    logic [32:0]           chunk_end;

    // only a final byte needs the output register
    assign o_stall = r_out_valid & i_stall & i_last_byte;
    assign accept  = i_valid & ~o_stall;
    assign lane    = r_count[1:0];

    assign is_ws    = (i_data_byte == CH_SPACE) || (i_data_byte == CH_LF) ||
                      (i_data_byte == CH_TAB)   || (i_data_byte == CH_CR);
    assign is_open  = (i_data_byte == CH_LBRACE) || (i_data_byte == CH_LBRACK);
    assign is_close = (i_data_byte == CH_RBRACE) || (i_data_byte == CH_RBRACK);

    // per-byte update of header words, counter and bracket tracker
    always_comb begin
        n_count     = r_count;
        n_ovf       = r_ovf;
        n_prefix    = r_prefix;
        n_version   = r_version;
        n_decl_len  = r_decl_len;
        n_chunk_len = r_chunk_len;
        n_chunk_typ = r_chunk_typ;
        n_depth     = r_depth;
        n_in_str    = r_in_str;
        n_escape    = r_escape;
        n_started   = r_started;
        n_jerr      = r_jerr;

        // header bytes sit in the first twenty positions
        if (r_count[31:5] == 27'd0) begin
            unique case (r_count[4:2])
                3'd0: begin
                    if (i_data_byte != GLB_MAGIC[8*lane +: 8]) begin
                        n_prefix = 1'b0;
                    end
                end
                3'd1: n_version[8*lane +: 8]   = i_data_byte;
                3'd2: n_decl_len[8*lane +: 8]  = i_data_byte;
                3'd3: n_chunk_len[8*lane +: 8] = i_data_byte;
                3'd4: n_chunk_typ[8*lane +: 8] = i_data_byte;
                default: ;
            endcase
        end

        if (r_jerr == JE_NONE) begin
            if (!r_started) begin
                if (is_open) begin
                    n_started = 1'b1;
                    n_depth   = DEPTH_BITS'(1);
                end else if (!is_ws) begin
                    n_jerr = JE_NOT_OBJ;
                end
            end else if (r_in_str) begin
                priority if (r_escape) begin
                    n_escape = 1'b0;
                end else if (i_data_byte == CH_BSLASH) begin
                    n_escape = 1'b1;
                end else if (i_data_byte == CH_QUOTE) begin
                    n_in_str = 1'b0;
                end else begin
                    n_in_str = r_in_str;
                end
            end else begin
                priority if (i_data_byte == CH_QUOTE) begin
                    n_in_str = 1'b1;
                end else if (is_open) begin
                    if (r_depth == DEPTH_MAX) begin
                        n_jerr = JE_DEPTH_OVF;
                    end else begin
                        n_depth = r_depth + DEPTH_BITS'(1);
                    end
                end else if (is_close) begin
                    if (r_depth == '0) begin
                        n_jerr = JE_EARLY_CLOSE;
                    end else begin
                        n_depth = r_depth - DEPTH_BITS'(1);
                    end
                end else begin
                    n_depth = r_depth;
                end
            end
        end

        if (r_count == 32'hFFFF_FFFF) begin
            n_ovf = 1'b1;
        end else begin
            n_count = r_count + 32'd1;
        end
    end

    // verdict from the state after this byte
    assign glb       = n_prefix && (n_count >= 32'd4);
    assign chunk_end = {1'b0, n_chunk_len} + {1'b0, GLB_MIN_BYTES};

    always_comb begin
        priority if (n_ovf) begin
            status = ST_OVERFLOW;
        end else if (glb) begin
            priority if (n_count < GLB_MIN_BYTES) begin
                status = ST_GLB_SHORT;
            end else if (n_version != GLB_VERSION) begin
                status = ST_BAD_VERSION;
            end else if (n_decl_len != n_count) begin
                status = ST_LEN_MISMATCH;
            end else if (n_chunk_typ != GLB_JSON_TYPE) begin
                status = ST_NOT_JSON_CHK;
            end else if ((n_chunk_len == 32'd0) || (chunk_end > {1'b0, n_count})) begin
                status = ST_BAD_CHUNK;
            end else begin
                status = ST_OK;
            end
        end else begin
            priority if ((n_jerr == JE_NOT_OBJ) || !n_started) begin
                status = ST_NOT_OBJ;
            end else if (n_jerr == JE_EARLY_CLOSE) begin
                status = ST_EARLY_CLOSE;
            end else if (n_jerr == JE_DEPTH_OVF) begin
                status = ST_OVERFLOW;
            end else if ((n_depth != '0) || n_in_str) begin
                status = ST_UNTERM;
            end else begin
                status = ST_OK;
            end
        end
    end

    always_comb begin
        n_out_valid = r_out_valid & i_stall;
        if (accept && i_last_byte) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (accept && i_last_byte)) begin
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_prefix    <= 1'b1;
            r_version   <= '0;
            r_decl_len  <= '0;
            r_chunk_len <= '0;
            r_chunk_typ <= '0;
            r_depth     <= '0;
            r_in_str    <= 1'b0;
            r_escape    <= 1'b0;
            r_started   <= 1'b0;
            r_jerr      <= JE_NONE;
        end else if (accept) begin
            r_count     <= n_count;
            r_ovf       <= n_ovf;
            r_prefix    <= n_prefix;
            r_version   <= n_version;
            r_decl_len  <= n_decl_len;
            r_chunk_len <= n_chunk_len;
            r_chunk_typ <= n_chunk_typ;
            r_depth     <= n_depth;
            r_in_str    <= n_in_str;
            r_escape    <= n_escape;
            r_started   <= n_started;
            r_jerr      <= n_jerr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    // result payload, loaded only by a final byte
    always_ff @(posedge i_clk) begin
        if (accept && i_last_byte) begin
            r_out_ok     <= (status == ST_OK);
            r_out_kind   <= glb;
            r_out_status <= status;
            r_out_total  <= n_count;
            r_out_chunk  <= glb ? n_chunk_len : 32'd0;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_payload_ok   = r_out_ok;
    assign o_payload_kind = r_out_kind;
    assign o_status_code  = r_out_status;
    assign o_total_bytes  = r_out_total;
    assign o_chunk_length = r_out_chunk;

endmodule

### hw/rtl/gjsc_checker.sv
// port-level checker for the structure check, bound to the top level
`include "glb_json_structure_check_assert.svh"

module gjsc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_stall,
    input logic        i_last_byte,
    input logic        o_valid,
    input logic        i_stall,
    input logic        o_payload_ok,
    input logic        o_payload_kind,
    input logic [3:0]  o_status_code,
    input logic [31:0] o_total_bytes,
    input logic [31:0] o_chunk_length
);
    import gjsc_pkg::*;

    // a stalled result beat stays
    `GJSC_ASSERT_NEXT(a_out_hold, o_valid && i_stall, o_valid && $stable(o_status_code))
    // the input only waits for a final byte behind a stalled result
    `GJSC_ASSERT_IMPL(a_stall_src, o_stall, o_valid && i_stall && i_last_byte)
    // ok flag agrees with the status code
    `GJSC_ASSERT_IMPL(a_ok_match, o_valid, o_payload_ok == (o_status_code == ST_OK))
    // json results carry no chunk length
    `GJSC_ASSERT_IMPL(a_json_chunk, o_valid && !o_payload_kind, o_chunk_length == 32'd0)
    // a passing glb payload holds the header and its chunk
    `GJSC_ASSERT_IMPL(a_glb_size, o_valid && o_payload_kind && o_payload_ok,
        (o_total_bytes >= GLB_MIN_BYTES) && (o_chunk_length != 32'd0))

endmodule

bind glb_json_structure_check gjsc_checker u_gjsc_checker (.*);
